/* rtl/core/lwe_phase_inner_product_macros.svh */
// ----------------------------------------------------------------------------
// LWE phase inner product: assertion macros
// Shared concurrent assertion forms for the checker of the phase block.
// ----------------------------------------------------------------------------
`ifndef LWE_PHASE_INNER_PRODUCT_MACROS_SVH
`define LWE_PHASE_INNER_PRODUCT_MACROS_SVH

// Same-cycle implication, switched off while reset is asserted.
`define LWEPIP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define LWEPIP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked across reset.
`define LWEPIP_ASSERT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/lwepip_pkg.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product: package
// Field widths, default modulus width and the control bundles between units.
// ----------------------------------------------------------------------------
package lwepip_pkg;

    localparam int unsigned FIELD_W          = 62;
    localparam int unsigned REG_W            = 63;
    localparam int unsigned MODULUS_BITS_DEF = 62;

    // Control of one bit-serial remainder lane.
    typedef struct packed {
        logic load;
        logic pass;
        logic step;
    } t_lane_ctl;

    // Control of the bit-serial modular multiplier.
    typedef struct packed {
        logic load;
        logic step;
    } t_mul_ctl;

endpackage

/* rtl/core/lwepip_rem_lane.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product: remainder lane
// Bit-serial restoring remainder of a 62-bit operand modulo q, one bit a cycle.
// ----------------------------------------------------------------------------
module lwepip_rem_lane #(
    parameter int unsigned MODULUS_BITS = lwepip_pkg::MODULUS_BITS_DEF
) (
    input  logic                              i_clk,
    input  lwepip_pkg::t_lane_ctl             i_ctl,
    input  logic [lwepip_pkg::FIELD_W-1:0]    i_value,
    input  logic [MODULUS_BITS:0]             i_q,
    output logic                              o_ge,
    output logic [MODULUS_BITS-1:0]           o_rem
);
    import lwepip_pkg::*;

    localparam int unsigned QW = MODULUS_BITS + 1;

    logic [FIELD_W-1:0]      r_shift;
    logic [MODULUS_BITS-1:0] r_rem;
    logic [QW-1:0]           trial;
    logic [QW:0]             diff;

    // Bring down the next bit and subtract q where it fits.
    assign trial = {r_rem, r_shift[FIELD_W-1]};
    assign diff  = {1'b0, trial} - {1'b0, i_q};
    assign o_ge  = REG_W'(r_shift) >= REG_W'(i_q);
    assign o_rem = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_shift <= i_value;
            r_rem   <= '0;
        end else if (i_ctl.pass) begin
            r_rem   <= r_shift[MODULUS_BITS-1:0];
        end else if (i_ctl.step) begin
            r_shift <= {r_shift[FIELD_W-2:0], 1'b0};
            r_rem   <= diff[QW] ? trial[MODULUS_BITS-1:0] : diff[MODULUS_BITS-1:0];
        end
    end

endmodule

/* rtl/core/lwepip_mulmod.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product: modular multiplier
// Bit-serial double-and-add product a * s mod q, most significant bit first.
// ----------------------------------------------------------------------------
module lwepip_mulmod #(
    parameter int unsigned MODULUS_BITS = lwepip_pkg::MODULUS_BITS_DEF
) (
    input  logic                    i_clk,
    input  lwepip_pkg::t_mul_ctl    i_ctl,
    input  logic [MODULUS_BITS-1:0] i_a,
    input  logic [MODULUS_BITS-1:0] i_s,
    input  logic [MODULUS_BITS:0]   i_q,
    output logic [MODULUS_BITS-1:0] o_prod
);
    import lwepip_pkg::*;

    localparam int unsigned W = MODULUS_BITS + 3;

    logic [MODULUS_BITS-1:0] r_a;
    logic [MODULUS_BITS-1:0] r_s;
    logic [MODULUS_BITS-1:0] r_r;
    logic [MODULUS_BITS-1:0] n_r;
    logic [W-1:0]            sum;
    logic [W-1:0]            sub1;
    logic [W-1:0]            sub2;

    // 2r + s stays below 3q, so one of three candidates is the residue.
    always_comb begin
        sum  = W'({r_r, 1'b0}) + W'(r_a[MODULUS_BITS-1] ? r_s : '0);
        sub1 = sum - W'(i_q);
        sub2 = sum - (W'(i_q) << 1);
        if (!sub2[W-1]) begin
            n_r = sub2[MODULUS_BITS-1:0];
        end else if (!sub1[W-1]) begin
            n_r = sub1[MODULUS_BITS-1:0];
        end else begin
            n_r = sum[MODULUS_BITS-1:0];
        end
    end

    assign o_prod = r_r;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_a <= i_a;
            r_s <= i_s;
            r_r <= '0;
        end else if (i_ctl.step) begin
            r_a <= {r_a[MODULUS_BITS-2:0], 1'b0};
            r_r <= n_r;
        end
    end

endmodule

/* rtl/core/lwe_phase_inner_product.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product
// Phase b - sum(a_i * s_i) mod q over a stream of coefficient pairs.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake                   Payload
//  req      i_req_valid / o_req_stall   body, mask, secret, start, end
//  res      o_res_valid / i_res_stall   phase value, range error
//  cfg      i_cfg_we                    modulus (63 bits)
//
//  From acceptance to the next free slot, a request passes through the range
//  check, the multiplier load, the multiplication and the done state when all
//  its operands lie below q; when one does not, a reduction pass through the
//  remainder lanes comes after the check. The bit-serial multiplier works on
//  one bit of the mask coefficient a cycle.
//  Reset is synchronous and active low; it clears the residue, the error flag
//  and the control state, and sets the modulus to 2^62.
//  A stalled result sits in the output register while the next request is
//  already being worked on; only a second result waits for it to drain.
//
module lwe_phase_inner_product #(
    parameter int unsigned MODULUS_BITS = lwepip_pkg::MODULUS_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Configuration
    input  logic                             i_cfg_we,
    input  logic [lwepip_pkg::REG_W-1:0]     i_cfg_wdata,
    // Request channel
    input  logic                             i_req_valid,
    output logic                             o_req_stall,
    input  logic [lwepip_pkg::FIELD_W-1:0]   i_body_value,
    input  logic [lwepip_pkg::FIELD_W-1:0]   i_mask_coef,
    input  logic [lwepip_pkg::FIELD_W-1:0]   i_secret_coef,
    input  logic                             i_start_flag,
    input  logic                             i_end_flag,
    // Result channel
    output logic                             o_res_valid,
    input  logic                             i_res_stall,
    output logic [lwepip_pkg::FIELD_W-1:0]   o_phase_value,
    output logic                             o_range_error
);
    import lwepip_pkg::*;

    localparam int unsigned QW = MODULUS_BITS + 1;
    localparam int unsigned CW = $clog2(FIELD_W);
    localparam logic [CW-1:0]    RED_LAST = CW'(FIELD_W - 1);
    localparam logic [CW-1:0]    MUL_LAST = CW'(MODULUS_BITS - 1);
    localparam logic [REG_W-1:0] Q_MIN    = REG_W'(2);
    localparam logic [REG_W-1:0] Q_MAX    = REG_W'(1) << MODULUS_BITS;
    localparam logic [REG_W-1:0] MOD_RST  = REG_W'(1) << (REG_W - 1);

    // The sequencer walks one request through range check, optional
    // reduction, multiplication and the final modular subtraction.
    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_CHECK  = 6'b000010,
        S_REDUCE = 6'b000100,
        S_MLOAD  = 6'b001000,
        S_MUL    = 6'b010000,
        S_DONE   = 6'b100000
    } t_state;

    t_state                  r_state;
    t_state                  n_state;
    logic [CW-1:0]           r_cnt;
    logic [CW-1:0]           n_cnt;
    logic [REG_W-1:0]        r_modulus;
    logic [QW-1:0]           r_q;
    logic                    r_start;
    logic                    r_end;
    logic                    r_err;
    logic [MODULUS_BITS-1:0] r_resid;
    logic                    r_seen;
    logic                    r_out_valid;
    logic [FIELD_W-1:0]      r_out_phase;
    logic                    r_out_err;

    logic [REG_W-1:0]        q_clamp;
    logic                    req_accept;
    logic                    out_load;
    logic                    any_ge;
    logic [FIELD_W-1:0]      acc_src;
    t_lane_ctl               lane_ctl;
    t_mul_ctl                mul_ctl;
    logic                    ge_acc;
    logic                    ge_a;
    logic                    ge_s;
    logic [MODULUS_BITS-1:0] rem_acc;
    logic [MODULUS_BITS-1:0] rem_a;
    logic [MODULUS_BITS-1:0] rem_s;
    logic [MODULUS_BITS-1:0] prod;
    logic [QW-1:0]           diff_pos;
    logic [QW:0]             diff_neg;
    logic [MODULUS_BITS-1:0] phase;

    // The effective modulus is the register value clamped to [2, 2^MODULUS_BITS].
    always_comb begin
        if (r_modulus < Q_MIN) begin
            q_clamp = Q_MIN;
        end else if (r_modulus > Q_MAX) begin
            q_clamp = Q_MAX;
        end else begin
            q_clamp = r_modulus;
        end
    end

    assign req_accept = i_req_valid && !o_req_stall;
    assign o_req_stall = (r_state != S_IDLE);

    // A start request loads the body; any other continues from the residue,
    // which a changed modulus may leave out of range, so it is reduced too.
    assign acc_src = i_start_flag ? i_body_value : FIELD_W'(r_resid);

    // Of the bodies, only that of a start request counts towards the range error.
    assign any_ge = ge_acc || ge_a || ge_s;

    always_comb begin
        lane_ctl.load = req_accept;
        lane_ctl.pass = (r_state == S_CHECK) && !any_ge;
        lane_ctl.step = (r_state == S_REDUCE);
        mul_ctl.load  = (r_state == S_MLOAD);
        mul_ctl.step  = (r_state == S_MUL);
    end

    lwepip_rem_lane #(.MODULUS_BITS(MODULUS_BITS)) u_lane_acc (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_value (acc_src),
        .i_q     (r_q),
        .o_ge    (ge_acc),
        .o_rem   (rem_acc)
    );

    lwepip_rem_lane #(.MODULUS_BITS(MODULUS_BITS)) u_lane_a (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_value (i_mask_coef),
        .i_q     (r_q),
        .o_ge    (ge_a),
        .o_rem   (rem_a)
    );

    lwepip_rem_lane #(.MODULUS_BITS(MODULUS_BITS)) u_lane_s (
        .i_clk   (i_clk),
        .i_ctl   (lane_ctl),
        .i_value (i_secret_coef),
        .i_q     (r_q),
        .o_ge    (ge_s),
        .o_rem   (rem_s)
    );

    lwepip_mulmod #(.MODULUS_BITS(MODULUS_BITS)) u_mul (
        .i_clk  (i_clk),
        .i_ctl  (mul_ctl),
        .i_a    (rem_a),
        .i_s    (rem_s),
        .i_q    (r_q),
        .o_prod (prod)
    );

    // Modular subtraction: both operands are below q, so adding q back once
    // repairs a negative difference.
    assign diff_pos = {1'b0, rem_acc} - {1'b0, prod};
    assign diff_neg = {2'b0, rem_acc} + {1'b0, r_q} - {2'b0, prod};
    assign phase    = diff_pos[QW-1] ? diff_neg[MODULUS_BITS-1:0]
                                     : diff_pos[MODULUS_BITS-1:0];

    // A finished result moves to the output register once that is free.
    assign out_load = (r_state == S_DONE) && r_end && (!r_out_valid || !i_res_stall);

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        case (r_state)
            S_IDLE: begin
                if (req_accept) begin
                    n_state = S_CHECK;
                end
            end
            S_CHECK: begin
                if (any_ge) begin
                    n_state = S_REDUCE;
                    n_cnt   = RED_LAST;
                end else begin
                    n_state = S_MLOAD;
                end
            end
            S_REDUCE: begin
                if (r_cnt == '0) begin
                    n_state = S_MLOAD;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_MLOAD: begin
                n_state = S_MUL;
                n_cnt   = MUL_LAST;
            end
            S_MUL: begin
                if (r_cnt == '0) begin
                    n_state = S_DONE;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            S_DONE: begin
                if (!r_end || out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and architectural state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_modulus   <= MOD_RST;
            r_err       <= 1'b0;
            r_resid     <= '0;
            r_seen      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
            if (req_accept) begin
                r_err <= i_start_flag ? 1'b0 : r_seen;
            end else if (r_state == S_CHECK) begin
                r_err <= r_err || (r_start && ge_acc) || ge_a || ge_s;
            end
            if (r_state == S_DONE) begin
                if (!r_end) begin
                    r_resid <= phase;
                    r_seen  <= r_err;
                end else if (out_load) begin
                    r_resid <= '0;
                    r_seen  <= 1'b0;
                end
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_res_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Request flags, latched modulus and result payload.
    always_ff @(posedge i_clk) begin
        if (req_accept) begin
            r_start <= i_start_flag;
            r_end   <= i_end_flag;
            r_q     <= q_clamp[QW-1:0];
        end
        if (out_load) begin
            r_out_phase <= FIELD_W'(phase);
            r_out_err   <= r_err;
        end
    end

    assign o_res_valid   = r_out_valid;
    assign o_phase_value = r_out_phase;
    assign o_range_error = r_out_err;

endmodule

/* rtl/core/lwepip_chk.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product: port checker
// Watches the ports of the phase block and is bound to its top level.
// ----------------------------------------------------------------------------
`include "lwe_phase_inner_product_macros.svh"

module lwepip_chk (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_req_valid,
    input  logic                           o_req_stall,
    input  logic                           o_res_valid,
    input  logic                           i_res_stall,
    input  logic [lwepip_pkg::FIELD_W-1:0] o_phase_value,
    input  logic                           o_range_error
);
    import lwepip_pkg::*;

    // A result held back by the consumer must not change.
    `LWEPIP_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && i_res_stall, o_res_valid && $stable(o_phase_value) && $stable(o_range_error), "result changed while stalled")

    // Once a request is accepted, the block is busy working on it.
    `LWEPIP_ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && !o_req_stall, o_req_stall, "request channel free right after a request")

    // A new result only appears while a request was being worked on.
    `LWEPIP_ASSERT_NOW(a_res_from_work, i_clk, i_rst_n, $rose(o_res_valid), $past(o_req_stall), "result without a request in progress")

    // Reset leaves the block idle with an empty output register.
    `LWEPIP_ASSERT_ALWAYS(a_reset_idle, i_clk, !i_rst_n, !o_res_valid && !o_req_stall, "block not idle after reset")

endmodule

bind lwe_phase_inner_product lwepip_chk u_lwepip_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req_valid),
    .o_req_stall   (o_req_stall),
    .o_res_valid   (o_res_valid),
    .i_res_stall   (i_res_stall),
    .o_phase_value (o_phase_value),
    .o_range_error (o_range_error)
);

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// LWE phase inner product: testbench
// Drives coefficient-pair requests into the phase block under several modulus
// settings, predicts each phase and range flag, and checks every result.
// ----------------------------------------------------------------------------
module tb_top;
    import lwepip_pkg::*;

    // Largest 62-bit value and the cap on the effective modulus, 2^62.
    localparam logic [63:0] MAX62 = 64'h3FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] Q_CAP = 64'h4000_0000_0000_0000;
    // Cycles allowed for work still in flight once the last result is in.
    localparam int unsigned SETTLE_CYCLES = 200;
    // Cycles without any accepted request or result before giving up.
    localparam int unsigned WATCHDOG_LIMIT = 5000;
    localparam int unsigned RANDOM_PER_PHASE = 72;
    localparam int unsigned NUM_PHASES = 11;

    // ------------------------------------------------------------------------
    // Scoreboard: keeps its own copy of the modulus, the running residue and
    // the error flag, and queues the phase expected for each closing request.
    // ------------------------------------------------------------------------
    class phase_scoreboard;
        typedef struct {
            logic [FIELD_W-1:0] phase;
            logic               range_error;
        } t_phase_result;

        t_phase_result    expected_q[$];
        logic [REG_W-1:0] modulus_reg;
        logic [63:0]      residue;
        logic             error_seen;
        int unsigned      failures;

        function new();
            modulus_reg = Q_CAP[REG_W-1:0];
            residue     = 64'd0;
            error_seen  = 1'b0;
            failures    = 0;
        endfunction

        function void set_modulus(logic [REG_W-1:0] value);
            modulus_reg = value;
        endfunction

        // The register value clamped to [2, 2^62].
        function logic [63:0] eff_modulus();
            logic [63:0] q;
            q = {1'b0, modulus_reg};
            if (q < 64'd2) q = 64'd2;
            if (q > Q_CAP) q = Q_CAP;
            return q;
        endfunction

        function logic [63:0] reduce_checked(logic [63:0] v, logic [63:0] q,
                                             inout logic err);
            if (v >= q) begin
                err = 1'b1;
                return v % q;
            end
            return v;
        endfunction

        function void note_request(logic [FIELD_W-1:0] body, logic [FIELD_W-1:0] mask,
                                   logic [FIELD_W-1:0] secret, logic start_flag,
                                   logic end_flag);
            logic [63:0]   q;
            logic [63:0]   acc;
            logic [63:0]   a;
            logic [63:0]   s;
            logic [63:0]   prod;
            logic [127:0]  wide;
            logic          err;
            t_phase_result r;
            q = eff_modulus();
            // A start reloads from the body; otherwise the residue carries on.
            if (start_flag) begin
                err = 1'b0;
                acc = reduce_checked(64'(body), q, err);
            end else begin
                err = error_seen;
                acc = residue % q;
            end
            a = reduce_checked(64'(mask), q, err);
            s = reduce_checked(64'(secret), q, err);
            wide = ({64'd0, a} * {64'd0, s}) % {64'd0, q};
            prod = wide[63:0];
            acc = (acc >= prod) ? acc - prod : acc + (q - prod);
            if (end_flag) begin
                r.phase       = acc[FIELD_W-1:0];
                r.range_error = err;
                expected_q.push_back(r);
                residue    = 64'd0;
                error_seen = 1'b0;
            end else begin
                residue    = acc & MAX62;
                error_seen = err;
            end
        endfunction

        function void check_result(logic [FIELD_W-1:0] phase, logic range_error);
            t_phase_result r;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: phase %h range_error %0b",
                             phase, range_error);
                return;
            end
            r = expected_q.pop_front();
            if (r.phase !== phase || r.range_error !== range_error) begin
                failures++;
                if (failures <= 10)
                    $display("result mismatch: expected phase %h range_error %0b, got %h %0b",
                             r.phase, r.range_error, phase, range_error);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Block ports. Every input has a known value from time zero.
    // ------------------------------------------------------------------------
    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_cfg_we = 1'b0;
    logic [REG_W-1:0]   i_cfg_wdata = '0;
    logic               i_req_valid = 1'b0;
    logic               o_req_stall;
    logic [FIELD_W-1:0] i_body_value = '0;
    logic [FIELD_W-1:0] i_mask_coef = '0;
    logic [FIELD_W-1:0] i_secret_coef = '0;
    logic               i_start_flag = 1'b0;
    logic               i_end_flag = 1'b0;
    logic               o_res_valid;
    logic               i_res_stall = 1'b0;
    logic [FIELD_W-1:0] o_phase_value;
    logic               o_range_error;

    phase_scoreboard sb;
    // When set, neither side idles: the closing stretch of the run.
    bit              quiet = 1'b0;
    int unsigned     idle_cycles = 0;
    int unsigned     stall_left = 0;
    bit              stall_on = 1'b0;

    lwe_phase_inner_product dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_valid   (i_req_valid),
        .o_req_stall   (o_req_stall),
        .i_body_value  (i_body_value),
        .i_mask_coef   (i_mask_coef),
        .i_secret_coef (i_secret_coef),
        .i_start_flag  (i_start_flag),
        .i_end_flag    (i_end_flag),
        .o_res_valid   (o_res_valid),
        .i_res_stall   (i_res_stall),
        .o_phase_value (o_phase_value),
        .o_range_error (o_range_error)
    );

    always #2 i_clk = ~i_clk;

    // Outside the quiet stretch the result side picks, at random, a stall burst or a
    // run in which it takes everything offered, each of random length. Stall changes only
    // at the falling edge, so the block sees a settled value at the rising one.
    always @(negedge i_clk) begin
        if (quiet) begin
            i_res_stall <= 1'b0;
        end else begin
            if (stall_left == 0) begin
                stall_on   = ($urandom_range(0, 2) == 0);
                stall_left = stall_on ? $urandom_range(1, 17) : $urandom_range(1, 40);
            end
            stall_left--;
            i_res_stall <= stall_on;
        end
    end

    // Both channels are sampled at the rising edge. An accepted request feeds
    // the predictor; an accepted result is checked against the oldest
    // expectation. The watchdog is cleared by any handshake on either side.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_req_valid && !o_req_stall)
                sb.note_request(i_body_value, i_mask_coef, i_secret_coef,
                                i_start_flag, i_end_flag);
            if (o_res_valid && !i_res_stall)
                sb.check_result(o_phase_value, o_range_error);
            if ((i_req_valid && !o_req_stall) || (o_res_valid && !i_res_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Offers one request, after an optional idle gap, and returns at the first
    // falling edge after it has been accepted. Valid is written once per edge:
    // without a gap it simply stays high for the next request.
    task automatic send_request(logic [FIELD_W-1:0] body, logic [FIELD_W-1:0] mask,
                                logic [FIELD_W-1:0] secret, logic start_flag,
                                logic end_flag);
        int unsigned gap;
        gap = (!quiet && $urandom_range(0, 3) == 0) ? $urandom_range(1, 17) : 0;
        if (gap != 0) begin
            i_req_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_req_valid   <= 1'b1;
        i_body_value  <= body;
        i_mask_coef   <= mask;
        i_secret_coef <= secret;
        i_start_flag  <= start_flag;
        i_end_flag    <= end_flag;
        @(posedge i_clk);
        while (o_req_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    // Holds off new requests until every expected result has been taken.
    task automatic drain_results();
        i_req_valid <= 1'b0;
        @(negedge i_clk);
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // The modulus is only changed with the block idle. A request without a
    // closing flag leaves no expectation behind, so the block is given time to
    // finish any such work before the write.
    task automatic write_modulus(logic [REG_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_modulus(value);
    endtask

    // Picks an operand for the current modulus. Clean operands stay below q,
    // with zero and q - 1 favoured; the others may be q or any 62-bit value.
    function automatic logic [FIELD_W-1:0] pick_operand(bit clean);
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] v;
        q = sb.eff_modulus();
        r = {$urandom(), $urandom()} & MAX62;
        case ($urandom_range(0, 9))
            0: begin
                v = 64'd0;
            end
            1: begin
                v = q - 64'd1;
            end
            2: begin
                v = clean ? q - 64'd1 : ((q > MAX62) ? MAX62 : q);
            end
            3: begin
                v = clean ? r % q : r;
            end
            4: begin
                v = clean ? q - 64'd1 : MAX62;
            end
            default: begin
                v = r % q;
            end
        endcase
        return v[FIELD_W-1:0];
    endfunction

    // A well-formed ciphertext: start on the first pair, end on the last.
    // The body of pairs after the first is ignored by the block, so it is
    // filled with anything at all.
    task automatic send_ciphertext(int unsigned len, bit clean);
        for (int unsigned i = 0; i < len; i++)
            send_request((i == 0) ? pick_operand(clean) : pick_operand(1'b0),
                         pick_operand(clean), pick_operand(clean),
                         (i == 0), (i == len - 1));
    endtask

    // Mostly short well-formed ciphertexts with the odd long one, mixed with
    // stray requests whose flags are random: restarts in mid-ciphertext,
    // pairs with no preceding start and lone closing pairs.
    task automatic random_traffic(int unsigned count);
        int unsigned sent;
        int unsigned len;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(0, 99) < 85) begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 24)
                                                  : $urandom_range(1, 6);
                send_ciphertext(len, ($urandom_range(0, 9) < 7));
                sent += len;
            end else begin
                send_request(pick_operand(1'b0), pick_operand(1'b0), pick_operand(1'b0),
                             1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                sent++;
            end
            if (!quiet && $urandom_range(0, 49) == 0)
                drain_results();
        end
    endtask

    initial begin
        logic [REG_W-1:0] moduli [NUM_PHASES];
        sb = new();

        // The register range is swept from below its floor to above its cap,
        // through tiny, mid-sized and near-maximal moduli. The last setting is
        // the reset value and is run with no idling on either side.
        moduli[0]  = 63'd0;
        moduli[1]  = 63'd1;
        moduli[2]  = 63'd2;
        moduli[3]  = 63'd3;
        moduli[4]  = 63'd97;
        moduli[5]  = 63'h7FFF_FFFF;
        moduli[6]  = Q_CAP[REG_W-1:0] - 63'd57;
        moduli[7]  = ({1'b0, MAX62[61:0]} & REG_W'({$urandom(), $urandom()})) | 63'd2;
        moduli[8]  = Q_CAP[REG_W-1:0] + 63'd5;
        moduli[9]  = {REG_W{1'b1}};
        moduli[10] = Q_CAP[REG_W-1:0];

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed requests at the reset modulus of 2^62: all-zero and
        // all-ones operands, a wrap below zero, a three-pair ciphertext, a
        // pair with no preceding start after a result, a restart in
        // mid-ciphertext and a full-width product.
        send_request(62'd0, 62'd0, 62'd0, 1'b1, 1'b1);
        send_request(MAX62[61:0], MAX62[61:0], MAX62[61:0], 1'b1, 1'b1);
        send_request(62'd0, 62'd1, 62'd1, 1'b1, 1'b1);
        send_request(62'd5, 62'd2, 62'd3, 1'b1, 1'b0);
        send_request(MAX62[61:0], 62'd1, 62'd1, 1'b0, 1'b0);
        send_request(62'd0, 62'd0, 62'd7, 1'b0, 1'b1);
        send_request(MAX62[61:0], 62'd3, 62'd4, 1'b0, 1'b1);
        send_request(62'd100, 62'd1, 62'd1, 1'b1, 1'b0);
        send_request(62'd50, 62'd2, 62'd2, 1'b1, 1'b1);
        send_request(62'd1, MAX62[61:0], 62'd2, 1'b1, 1'b1);

        for (int unsigned p = 0; p < NUM_PHASES; p++) begin
            if (p == NUM_PHASES - 1)
                quiet = 1'b1;
            write_modulus(moduli[p]);
            if (p == 4) begin
                // Range checks at q = 97: each operand at or above q flags
                // the ciphertext, an error carries to the closing pair, a body
                // without a start is not checked, and a restart clears the flag.
                send_request(62'd97, 62'd0, 62'd0, 1'b1, 1'b1);
                send_request(62'd0, 62'd200, 62'd1, 1'b1, 1'b1);
                send_request(62'd0, 62'd1, 62'd97, 1'b1, 1'b1);
                send_request(62'd96, 62'd96, 62'd96, 1'b1, 1'b1);
                send_request(62'd1, 62'd100, 62'd1, 1'b1, 1'b0);
                send_request(62'd0, 62'd1, 62'd1, 1'b0, 1'b1);
                send_request(62'd5, 62'd1, 62'd1, 1'b1, 1'b0);
                send_request(MAX62[61:0], 62'd2, 62'd2, 1'b0, 1'b1);
                send_request(62'd3, 62'd100, 62'd1, 1'b1, 1'b0);
                send_request(62'd3, 62'd1, 62'd1, 1'b1, 1'b1);
            end
            random_traffic(RANDOM_PER_PHASE);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.pending() != 0)
            $display("%0d expected results never arrived", sb.pending());
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
